[rtl/core/derint_pkg.sv]
package derint_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned EXT_W     = VALUE_W + 1;
    localparam int unsigned MAX_BYTES = 9;
    localparam int unsigned LEN_W     = 4;

    localparam logic [7:0] TAG_INTEGER = 8'h02;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ext;
        logic [LEN_W-1:0]   len;
    } t_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qsts;

    function automatic t_byte content_byte(input t_item item, input logic [LEN_W-1:0] idx);
        t_byte b;
        b = 8'h00;
        case (idx)
            4'd0: b = item.value[7:0];
            4'd1: b = item.value[15:8];
            4'd2: b = item.value[23:16];
            4'd3: b = item.value[31:24];
            4'd4: b = item.value[39:32];
            4'd5: b = item.value[47:40];
            4'd6: b = item.value[55:48];
            4'd7: b = item.value[63:56];
            4'd8: b = {8{item.ext}};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/derint_front.sv]
module derint_front (
    input  logic [63:0]     i_value_bits,
    input  logic            i_is_signed,
    output derint_pkg::t_item o_item
);

    logic [derint_pkg::EXT_W-1:0]     x;
    logic [derint_pkg::EXT_W-1:0]     diff;
    logic [derint_pkg::MAX_BYTES-1:0] fits;
    logic [derint_pkg::LEN_W-1:0]     len;

    assign x    = {i_is_signed & i_value_bits[63], i_value_bits};
    assign diff = x ^ {derint_pkg::EXT_W{x[derint_pkg::EXT_W-1]}};

    always_comb begin
        for (int i = 0; i < derint_pkg::MAX_BYTES; i++) begin
            fits[i] = (diff & ~((derint_pkg::EXT_W'(1) << (8 * i + 7))
                                - derint_pkg::EXT_W'(1))) == '0;
        end
    end

    always_comb begin
        len = derint_pkg::LEN_W'(derint_pkg::MAX_BYTES);
        for (int i = derint_pkg::MAX_BYTES - 1; i >= 0; i--) begin
            if (fits[i]) begin
                len = derint_pkg::LEN_W'(i + 1);
            end
        end
    end

    assign o_item.value = i_value_bits;
    assign o_item.ext   = x[derint_pkg::EXT_W-1];
    assign o_item.len   = len;

endmodule

[rtl/core/derint_queue.sv]
module derint_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  derint_pkg::t_qctl i_ctl,
    input  derint_pkg::t_item i_wdata,
    output derint_pkg::t_item o_rdata,
    output derint_pkg::t_qsts o_sts
);

    derint_pkg::t_item r_mem [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_sts.full  = (r_count == 2'd2);
    assign o_sts.empty = (r_count == 2'd0);
    assign do_push     = i_ctl.push && !o_sts.full;
    assign do_pop      = i_ctl.pop && !o_sts.empty;
    assign o_rdata     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/derint_back.sv]
module derint_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  derint_pkg::t_item i_item,
    input  logic              i_item_valid,
    output logic              o_item_done,
    output logic [7:0]        o_out_byte,
    output logic              o_last_byte,
    output logic              o_empty,
    input  logic              i_pop
);

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]                   r_phase, n_phase;
    logic [derint_pkg::LEN_W-1:0] r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_out_byte, n_out_byte;
    logic                         r_out_last, n_out_last;
    logic                         can_load;

    assign can_load = !r_out_valid || i_pop;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_item_done = 1'b0;
        if (can_load) begin
            unique case (r_phase)
                PH_TAG: begin
                    if (i_item_valid) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = derint_pkg::TAG_INTEGER;
                        n_out_last  = 1'b0;
                        n_phase     = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = {4'h0, i_item.len};
                    n_out_last  = 1'b0;
                    n_idx       = i_item.len - derint_pkg::LEN_W'(1);
                    n_phase     = PH_DATA;
                end
                PH_DATA: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = derint_pkg::content_byte(i_item, r_idx);
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        o_item_done = 1'b1;
                        n_phase     = PH_TAG;
                    end else begin
                        n_idx = r_idx - derint_pkg::LEN_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_idx      <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;
    assign o_empty     = !r_out_valid;

endmodule

[rtl/core/der_integer_encoder_top.sv]
// Channel   Direction  Handshake         Payload
// input     in         i_push / o_full   i_value_bits[63:0], i_is_signed
// result    out        o_empty / i_pop   o_out_byte[7:0], o_last_byte
//
// Each value yields a tag byte, a length byte and 1 to 9 content bytes, all of
// which pass one by one through the byte serializer; that serializer sets the rate.
// Values are classified as they arrive and wait in a two-entry queue.
// Reset is synchronous, clears the queue and marks the result register empty.
// A low pop holds the current byte; o_full rises only while two values wait.
module der_integer_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_value_bits,
    input  logic        i_is_signed,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    derint_pkg::t_item w_front_item;
    derint_pkg::t_item w_head_item;
    derint_pkg::t_qctl w_qctl;
    derint_pkg::t_qsts w_qsts;
    logic              w_item_done;

    derint_front u_front (
        .i_value_bits (i_value_bits),
        .i_is_signed  (i_is_signed),
        .o_item       (w_front_item)
    );

    assign w_qctl.push = i_push;
    assign w_qctl.pop  = w_item_done;

    derint_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_wdata (w_front_item),
        .o_rdata (w_head_item),
        .o_sts   (w_qsts)
    );

    derint_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_head_item),
        .i_item_valid (!w_qsts.empty),
        .o_item_done  (w_item_done),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .o_empty      (o_empty),
        .i_pop        (i_pop)
    );

    assign o_full = w_qsts.full;

endmodule

[rtl/core/derint_checker.sv]
module derint_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_out_byte,
    input logic       o_last_byte
);

    logic r_expect_tag;
    logic r_expect_len;
    logic pop_ok;

    assign pop_ok = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_tag <= 1'b1;
            r_expect_len <= 1'b0;
        end else if (pop_ok) begin
            r_expect_tag <= o_last_byte;
            r_expect_len <= r_expect_tag;
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("Result shown right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte) && $stable(o_last_byte)))
        else $error("Stalled result changed.");

    a_tag_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && r_expect_tag) |-> (o_out_byte == derint_pkg::TAG_INTEGER && !o_last_byte))
        else $error("Encoding does not open with the tag byte.");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && r_expect_len) |->
            (o_out_byte >= 8'd1 && o_out_byte <= 8'd9 && !o_last_byte))
        else $error("Length byte out of range.");

endmodule

bind der_integer_encoder_top derint_checker u_derint_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_empty     (o_empty),
    .i_pop       (i_pop),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte)
);

[dv/tb_der_integer_encoder_top.sv]
`timescale 1ns / 100ps

module tb_der_integer_encoder_top;

    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_ITEMS   = 60;

    localparam logic [63:0] NEG_FILL7 = 64'hFE00_0000_0000_0000;
    localparam logic [63:0] NEG_FILL8 = 64'hFF00_0000_0000_0000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_der_byte;

    typedef struct packed {
        logic [63:0] value;
        logic        sgn;
        logic [3:0]  exp_len;
        logic [87:0] exp_bytes;
    } t_value_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [63:0] i_value_bits;
    logic        i_is_signed;
    logic        o_empty;
    logic        i_pop;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    t_der_byte expected_bytes[$];
    t_der_byte head_byte;
    int        mismatches = 0;
    bit        calm_phase = 1'b0;

    // A typed length of zero means the row is checked against the predictor.
    t_value_row value_rows [0:20] = '{
        '{64'h0000_0000_0000_0000, 1'b0, 4'd3,  88'h02_01_00},
        '{64'h0000_0000_0000_0000, 1'b1, 4'd3,  88'h02_01_00},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd11, 88'h02_09_00_FF_FF_FF_FF_FF_FF_FF_FF},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd3,  88'h02_01_FF},
        '{64'h8000_0000_0000_0000, 1'b1, 4'd10, 88'h02_08_80_00_00_00_00_00_00_00},
        '{64'h8000_0000_0000_0000, 1'b0, 4'd11, 88'h02_09_00_80_00_00_00_00_00_00_00},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd10, 88'h02_08_7F_FF_FF_FF_FF_FF_FF_FF},
        '{64'h0000_0000_0000_007F, 1'b0, 4'd0,  88'h0},
        '{64'h0000_0000_0000_0080, 1'b0, 4'd0,  88'h0},
        '{64'h0000_0000_0000_0080, 1'b1, 4'd0,  88'h0},
        '{64'hFFFF_FFFF_FFFF_FF80, 1'b1, 4'd0,  88'h0},
        '{64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 4'd0,  88'h0},
        '{64'h0000_0000_0000_00FF, 1'b0, 4'd0,  88'h0},
        '{64'h0000_0000_0000_0100, 1'b1, 4'd0,  88'h0},
        '{64'h00FF_FFFF_FFFF_FFFF, 1'b0, 4'd0,  88'h0},
        '{64'hFF80_0000_0000_0000, 1'b1, 4'd0,  88'h0},
        '{64'hFF7F_FFFF_FFFF_FFFF, 1'b1, 4'd0,  88'h0},
        '{64'h0123_4567_89AB_CDEF, 1'b0, 4'd0,  88'h0},
        '{64'hFEDC_BA98_7654_3210, 1'b1, 4'd0,  88'h0},
        '{64'hFEDC_BA98_7654_3210, 1'b0, 4'd0,  88'h0},
        '{64'h0000_0000_0000_0001, 1'b1, 4'd0,  88'h0}
    };

    der_integer_encoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_value_bits (i_value_bits),
        .i_is_signed  (i_is_signed),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void predict_encoding(input logic [63:0] value, input logic sgn);
        logic [7:0]  lsb_first [derint_pkg::MAX_BYTES];
        logic [63:0] v;
        logic [63:0] fill7;
        logic [63:0] fill8;
        logic [63:0] stop;
        int          n;
        bit          done;
        v     = value;
        fill7 = '0;
        fill8 = '0;
        stop  = '0;
        n     = 0;
        done  = 1'b0;
        if (sgn && value[63]) begin
            fill7 = NEG_FILL7;
            fill8 = NEG_FILL8;
            stop  = '1;
        end
        while (!done && n < derint_pkg::MAX_BYTES) begin
            lsb_first[n] = v[7:0];
            n++;
            if (((v >> 7) | fill7) == stop) begin
                done = 1'b1;
            end else begin
                v = (v >> 8) | fill8;
            end
        end
        expected_bytes.push_back('{derint_pkg::TAG_INTEGER, 1'b0});
        expected_bytes.push_back('{8'(n), 1'b0});
        for (int k = n - 1; k >= 0; k--) begin
            expected_bytes.push_back('{lsb_first[k], k == 0});
        end
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          nbytes;
        nbytes = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
            0: begin
                v = {$urandom, $urandom};
            end
            1: begin
                v = {$urandom, $urandom} & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * nbytes));
            end
            2: begin
                v = ~({$urandom, $urandom} & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * nbytes)));
            end
            default: begin
                v = (64'd1 << (8 * nbytes - 1)) + 64'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic hold_off_push();
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_value(input logic [63:0] value, input logic sgn,
                              input logic [3:0] exp_len, input logic [87:0] exp_bytes);
        i_push       <= 1'b1;
        i_value_bits <= value;
        i_is_signed  <= sgn;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (exp_len != 0) begin
            for (int k = 0; k < exp_len; k++) begin
                expected_bytes.push_back('{exp_bytes[8 * (exp_len - 1 - k) +: 8],
                                           k == exp_len - 1});
            end
        end else begin
            predict_encoding(value, sgn);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_push       <= 1'b0;
        i_value_bits <= '0;
        i_is_signed  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (value_rows[i]) begin
            hold_off_push();
            send_value(value_rows[i].value, value_rows[i].sgn,
                       value_rows[i].exp_len, value_rows[i].exp_bytes);
        end
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item >= RANDOM_ITEMS - CALM_ITEMS) begin
                calm_phase = 1'b1;
            end
            hold_off_push();
            send_value(random_value(), 1'($urandom_range(0, 1)), 4'd0, 88'h0);
        end
        i_push <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        i_pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm_phase && $urandom_range(0, 7) == 0) begin
                i_pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_bytes.size() == 0) begin
                $error("Unexpected transaction: out_byte %02h last_byte %0b",
                       o_out_byte, o_last_byte);
                mismatches++;
            end else begin
                head_byte = expected_bytes.pop_front();
                if (o_out_byte !== head_byte.data) begin
                    $error("out_byte: expected %02h, actual %02h", head_byte.data, o_out_byte);
                    mismatches++;
                end
                if (o_last_byte !== head_byte.last) begin
                    $error("last_byte: expected %0b, actual %0b", head_byte.last, o_last_byte);
                    mismatches++;
                end
            end
        end
    end

endmodule

[sim.f]
rtl/core/derint_pkg.sv
rtl/core/derint_front.sv
rtl/core/derint_queue.sv
rtl/core/derint_back.sv
rtl/core/der_integer_encoder_top.sv
rtl/core/derint_checker.sv
dv/tb_der_integer_encoder_top.sv
